[rtl/assert_macros.svh]
// Assertion helper macros for the mailbox block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define BMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication checked on the same edge.
`define BMF_ASSERT_IMP(lbl, ante, cons, msg) \
    `BMF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/bmf_pkg.sv]
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the blocking mailbox FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

    localparam int ITEM_DEPTH_DEF      = 16;
    localparam int WAITER_DEPTH_DEF    = 8;
    localparam int DATA_WIDTH_DEF      = 32;
    localparam int THREAD_ID_WIDTH_DEF = 8;

    localparam int BOUND_W = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register index (paddr[2])
    localparam logic CFG_IDX_BOUND = 1'b0;

    typedef enum logic [2:0] {
        REQ_TRY_PUT  = 3'd0,
        REQ_TRY_GET  = 3'd1,
        REQ_TRY_PEEK = 3'd2,
        REQ_PUT      = 3'd3,
        REQ_GET      = 3'd4,
        REQ_PEEK     = 3'd5
    } t_req_type;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_FAIL    = 3'd1,
        ST_SUSP    = 3'd2,
        ST_WOKEN   = 3'd3,
        ST_REJECT  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ_RD,
        S_REQ,
        S_CAS_RD,
        S_CAS,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic capture;
        logic eval;
        logic cas_get;
        logic cas_put;
        logic emit_final;
    } t_ctrl_cmd;

    typedef struct packed {
        logic req_cascade;
        logic req_base;
        logic get_ok;
        logic put_ok;
        logic get_peek;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/bmf_ram.sv]
// ----------------------------------------------------------------------------
// bmf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/bmf_ctrl.sv]
// ----------------------------------------------------------------------------
// bmf_ctrl
// Request sequencer: evaluates a request, then runs the wakeup cascade.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_ctrl #(
    parameter int WAITER_DEPTH = bmf_pkg::WAITER_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire bmf_pkg::t_dp_stat   i_stat,
    output bmf_pkg::t_ctrl_cmd       o_cmd
);

    // cascade depth never exceeds the number of parked waiters
    localparam int DW = $clog2(2 * WAITER_DEPTH + 1);

    bmf_pkg::t_state r_state, n_state;
    logic            r_base, n_base;
    logic [DW-1:0]   r_depth, n_depth;
    logic            kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmf_pkg::S_IDLE;
            r_base  <= 1'b0;
            r_depth <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_depth <= n_depth;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_depth    = r_depth;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        kind       = r_base ^ r_depth[0];
        unique case (r_state)
            bmf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bmf_pkg::S_REQ_RD;
                end
            end
            bmf_pkg::S_REQ_RD: begin
                n_state = bmf_pkg::S_REQ;
            end
            bmf_pkg::S_REQ: begin
                o_cmd.eval = 1'b1;
                n_base     = i_stat.req_base;
                n_depth    = '0;
                n_state    = i_stat.req_cascade ? bmf_pkg::S_CAS_RD : bmf_pkg::S_FINAL;
            end
            bmf_pkg::S_CAS_RD: begin
                n_state = bmf_pkg::S_CAS;
            end
            bmf_pkg::S_CAS: begin
                priority if (!kind && i_stat.get_ok) begin
                    if (i_stat.out_free) begin
                        o_cmd.cas_get = 1'b1;
                        if (!i_stat.get_peek) begin
                            n_depth = r_depth + 1'b1;
                        end
                        n_state = bmf_pkg::S_CAS_RD;
                    end
                end else if (kind && i_stat.put_ok) begin
                    if (i_stat.out_free) begin
                        o_cmd.cas_put = 1'b1;
                        n_depth       = r_depth + 1'b1;
                        n_state       = bmf_pkg::S_CAS_RD;
                    end
                end else if (r_depth == '0) begin
                    n_state = bmf_pkg::S_FINAL;
                end else begin
                    n_depth = r_depth - 1'b1;
                end
            end
            bmf_pkg::S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = bmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/bmf_dp.sv]
// ----------------------------------------------------------------------------
// bmf_dp
// Datapath: item store, put and get waiter queues, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_dp #(
    parameter int ITEM_DEPTH      = bmf_pkg::ITEM_DEPTH_DEF,
    parameter int WAITER_DEPTH    = bmf_pkg::WAITER_DEPTH_DEF,
    parameter int DATA_WIDTH      = bmf_pkg::DATA_WIDTH_DEF,
    parameter int THREAD_ID_WIDTH = bmf_pkg::THREAD_ID_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bmf_pkg::t_ctrl_cmd           i_cmd,
    output bmf_pkg::t_dp_stat                 o_stat,
    input  wire logic [bmf_pkg::BOUND_W-1:0]  i_bound,
    input  wire logic [2:0]                   i_req_type,
    input  wire logic [THREAD_ID_WIDTH-1:0]   i_thread_id,
    input  wire logic [DATA_WIDTH-1:0]        i_item_data,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [2:0]                        o_status,
    output logic [THREAD_ID_WIDTH-1:0]        o_target_thread,
    output logic [DATA_WIDTH-1:0]             o_out_data,
    output logic                              o_data_valid,
    output logic                              o_last
);

    localparam int IA = $clog2(ITEM_DEPTH);
    localparam int IC = $clog2(ITEM_DEPTH + 1);
    localparam int IS = IA + 2;
    localparam int CW = (IC > bmf_pkg::BOUND_W) ? IC : bmf_pkg::BOUND_W;
    localparam int WA = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int WC = $clog2(WAITER_DEPTH + 1);
    localparam int WS = WA + 2;
    localparam int T  = THREAD_ID_WIDTH;
    localparam int D  = DATA_WIDTH;

    // request registers
    logic [2:0]   r_kind;
    logic [T-1:0] r_thr;
    logic [D-1:0] r_data;

    // queue pointers
    logic [IA-1:0] r_ihead, n_ihead;
    logic [IC-1:0] r_icount, n_icount;
    logic [WA-1:0] r_phead, n_phead, r_ghead, n_ghead;
    logic [WC-1:0] r_pcount, n_pcount, r_gcount, n_gcount;

    // final status of the request
    bmf_pkg::t_status r_fin_st, n_fin_st;
    logic [D-1:0]     r_fin_data, n_fin_data;
    logic             r_fin_dv, n_fin_dv;

    // result register
    logic             r_ovalid;
    logic [2:0]       r_ost;
    logic [T-1:0]     r_othr;
    logic [D-1:0]     r_odata;
    logic             r_odv, r_olast;

    logic [D-1:0]   item_rdata, item_wdata;
    logic [T+D-1:0] pw_rdata;
    logic [T:0]     gw_rdata;
    logic           item_we, ipush, ipop, ppush, ppop, gpush, gpop;
    logic           full, pfull, gfull;
    logic [IS-1:0]  itail_sum;
    logic [IA-1:0]  itail;
    logic [WS-1:0]  ptail_sum, gtail_sum;
    logic [WA-1:0]  ptail, gtail;

    assign full  = (CW'(r_icount) >= CW'(ITEM_DEPTH))
                || ((i_bound != '0) && (CW'(r_icount) >= CW'(i_bound)));
    assign pfull = (r_pcount == WC'(WAITER_DEPTH));
    assign gfull = (r_gcount == WC'(WAITER_DEPTH));

    always_comb begin
        itail_sum = IS'(r_ihead) + IS'(r_icount);
        if (itail_sum >= IS'(ITEM_DEPTH)) begin
            itail_sum = itail_sum - IS'(ITEM_DEPTH);
        end
        itail = itail_sum[IA-1:0];
        ptail_sum = WS'(r_phead) + WS'(r_pcount);
        if (ptail_sum >= WS'(WAITER_DEPTH)) begin
            ptail_sum = ptail_sum - WS'(WAITER_DEPTH);
        end
        ptail = ptail_sum[WA-1:0];
        gtail_sum = WS'(r_ghead) + WS'(r_gcount);
        if (gtail_sum >= WS'(WAITER_DEPTH)) begin
            gtail_sum = gtail_sum - WS'(WAITER_DEPTH);
        end
        gtail = gtail_sum[WA-1:0];
    end

    bmf_ram #(.WIDTH(D), .DEPTH(ITEM_DEPTH)) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (item_we),
        .i_waddr (itail),
        .i_wdata (item_wdata),
        .i_raddr (r_ihead),
        .o_rdata (item_rdata)
    );

    bmf_ram #(.WIDTH(T + D), .DEPTH(WAITER_DEPTH)) u_put_ram (
        .i_clk   (i_clk),
        .i_we    (ppush),
        .i_waddr (ptail),
        .i_wdata ({r_data, r_thr}),
        .i_raddr (r_phead),
        .o_rdata (pw_rdata)
    );

    bmf_ram #(.WIDTH(T + 1), .DEPTH(WAITER_DEPTH)) u_get_ram (
        .i_clk   (i_clk),
        .i_we    (gpush),
        .i_waddr (gtail),
        .i_wdata ({r_thr, (r_kind == bmf_pkg::REQ_PEEK)}),
        .i_raddr (r_ghead),
        .o_rdata (gw_rdata)
    );

    // request evaluation and cascade actions
    always_comb begin
        item_we    = 1'b0;
        item_wdata = r_data;
        ipush      = 1'b0;
        ipop       = 1'b0;
        ppush      = 1'b0;
        ppop       = 1'b0;
        gpush      = 1'b0;
        gpop       = 1'b0;
        n_fin_st   = r_fin_st;
        n_fin_data = r_fin_data;
        n_fin_dv   = r_fin_dv;
        o_stat     = '0;
        if (i_cmd.eval) begin
            n_fin_st   = bmf_pkg::ST_FAIL;
            n_fin_data = '0;
            n_fin_dv   = 1'b0;
            unique case (r_kind)
                bmf_pkg::REQ_TRY_PUT, bmf_pkg::REQ_PUT: begin
                    priority if (!full) begin
                        item_we            = 1'b1;
                        ipush              = 1'b1;
                        n_fin_st           = bmf_pkg::ST_DONE;
                        o_stat.req_cascade = 1'b1;
                    end else if (r_kind == bmf_pkg::REQ_TRY_PUT) begin
                        n_fin_st = bmf_pkg::ST_FAIL;
                    end else if (pfull) begin
                        n_fin_st = bmf_pkg::ST_REJECT;
                    end else begin
                        ppush    = 1'b1;
                        n_fin_st = bmf_pkg::ST_SUSP;
                    end
                end
                bmf_pkg::REQ_TRY_GET, bmf_pkg::REQ_TRY_PEEK,
                bmf_pkg::REQ_GET, bmf_pkg::REQ_PEEK: begin
                    priority if (r_icount != '0) begin
                        n_fin_st   = bmf_pkg::ST_DONE;
                        n_fin_data = item_rdata;
                        n_fin_dv   = 1'b1;
                        if (r_kind == bmf_pkg::REQ_TRY_GET || r_kind == bmf_pkg::REQ_GET) begin
                            ipop               = 1'b1;
                            o_stat.req_cascade = 1'b1;
                            o_stat.req_base    = 1'b1;
                        end
                    end else if (r_kind == bmf_pkg::REQ_TRY_GET
                              || r_kind == bmf_pkg::REQ_TRY_PEEK) begin
                        n_fin_st = bmf_pkg::ST_FAIL;
                    end else if (gfull) begin
                        n_fin_st = bmf_pkg::ST_REJECT;
                    end else begin
                        gpush    = 1'b1;
                        n_fin_st = bmf_pkg::ST_SUSP;
                    end
                end
                default: begin
                    n_fin_st = bmf_pkg::ST_FAIL;
                end
            endcase
        end
        if (i_cmd.cas_get) begin
            gpop = 1'b1;
            ipop = !gw_rdata[0];
        end
        if (i_cmd.cas_put) begin
            ppop       = 1'b1;
            item_we    = 1'b1;
            ipush      = 1'b1;
            item_wdata = pw_rdata[T+:D];
        end
        o_stat.get_ok   = (r_gcount != '0) && (r_icount != '0);
        o_stat.put_ok   = (r_pcount != '0) && !full;
        o_stat.get_peek = gw_rdata[0];
        o_stat.out_free = !r_ovalid || i_out_ready;
    end

    always_comb begin
        n_ihead  = r_ihead;
        n_phead  = r_phead;
        n_ghead  = r_ghead;
        n_icount = r_icount;
        n_pcount = r_pcount;
        n_gcount = r_gcount;
        if (ipop) begin
            n_ihead  = (r_ihead == IA'(ITEM_DEPTH - 1)) ? '0 : r_ihead + 1'b1;
            n_icount = r_icount - 1'b1;
        end
        if (ipush) begin
            n_icount = r_icount + 1'b1;
        end
        if (ppop) begin
            n_phead  = (r_phead == WA'(WAITER_DEPTH - 1)) ? '0 : r_phead + 1'b1;
            n_pcount = r_pcount - 1'b1;
        end
        if (ppush) begin
            n_pcount = r_pcount + 1'b1;
        end
        if (gpop) begin
            n_ghead  = (r_ghead == WA'(WAITER_DEPTH - 1)) ? '0 : r_ghead + 1'b1;
            n_gcount = r_gcount - 1'b1;
        end
        if (gpush) begin
            n_gcount = r_gcount + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ihead  <= '0;
            r_icount <= '0;
            r_phead  <= '0;
            r_pcount <= '0;
            r_ghead  <= '0;
            r_gcount <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ihead  <= n_ihead;
            r_icount <= n_icount;
            r_phead  <= n_phead;
            r_pcount <= n_pcount;
            r_ghead  <= n_ghead;
            r_gcount <= n_gcount;
            if (i_cmd.cas_get || i_cmd.cas_put || i_cmd.emit_final) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fin_st   <= n_fin_st;
        r_fin_data <= n_fin_data;
        r_fin_dv   <= n_fin_dv;
        if (i_cmd.capture) begin
            r_kind <= i_req_type;
            r_thr  <= i_thread_id;
            r_data <= i_item_data;
        end
        priority if (i_cmd.cas_get) begin
            r_ost   <= bmf_pkg::ST_WOKEN;
            r_othr  <= gw_rdata[T:1];
            r_odata <= item_rdata;
            r_odv   <= 1'b1;
            r_olast <= 1'b0;
        end else if (i_cmd.cas_put) begin
            r_ost   <= bmf_pkg::ST_WOKEN;
            r_othr  <= pw_rdata[T-1:0];
            r_odata <= '0;
            r_odv   <= 1'b0;
            r_olast <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_ost   <= r_fin_st;
            r_othr  <= r_thr;
            r_odata <= r_fin_data;
            r_odv   <= r_fin_dv;
            r_olast <= 1'b1;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ost;
    assign o_target_thread = r_othr;
    assign o_out_data      = r_odata;
    assign o_data_valid    = r_odv;
    assign o_last          = r_olast;

endmodule

`default_nettype wire

[rtl/blocking_mailbox_fifo_unit.sv]
// ----------------------------------------------------------------------------
// blocking_mailbox_fifo_unit
// Bounded mailbox with blocking put/get/peek between threads.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on the slave stream: tuser = req_type, tdata = thread id
//    (low bits) then the put data word. One request is in work at a time;
//    tready is high only while the sequencer is idle.
//  - Results leave on the master stream: tuser = status then data_valid,
//    tdata = target thread then delivered item, tlast on the requester's own
//    result, which always comes after every wakeup it caused.
//  - Sequencing: a transfer is captured in S_IDLE and the request is evaluated
//    in S_REQ after S_REQ_RD (item and waiter RAM reads are registered); each
//    wakeup runs S_CAS_RD then S_CAS, each fallback step of the cascade stays
//    in S_CAS, and S_FINAL loads the final result. A request that starts no
//    cascade (fail, suspend, reject, peek, unknown kind) goes from S_REQ to
//    S_FINAL; a put or get that completes runs the cascade check first.
//  - A stalled receiver holds the one-deep result register and the cascade
//    waits on it; a new request can still be taken while the last result of
//    the previous one waits.
//  - Reset clears all counts and pointers and the bound register (bound 0:
//    only the store depth limits). Store contents need no clearing.
//  - mailbox_bound is written through the APB port at address 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module blocking_mailbox_fifo_unit #(
    parameter int ITEM_DEPTH      = bmf_pkg::ITEM_DEPTH_DEF,
    parameter int WAITER_DEPTH    = bmf_pkg::WAITER_DEPTH_DEF,
    parameter int DATA_WIDTH      = bmf_pkg::DATA_WIDTH_DEF,
    parameter int THREAD_ID_WIDTH = bmf_pkg::THREAD_ID_WIDTH_DEF,
    localparam int TD_W = ((THREAD_ID_WIDTH + DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request stream
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [TD_W-1:0]              i_s_axis_tdata,  // thread_id, item_data
    input  wire logic [2:0]                   i_s_axis_tuser,  // req_type
    // result stream
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic [TD_W-1:0]                   o_m_axis_tdata,  // target_thread, out_data
    output logic [3:0]                        o_m_axis_tuser,  // status, data_valid
    output logic                              o_m_axis_tlast,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bmf_pkg::APB_AW-1:0]   paddr,
    input  wire logic [bmf_pkg::APB_DW-1:0]   pwdata,
    output logic [bmf_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    localparam int T = THREAD_ID_WIDTH;
    localparam int D = DATA_WIDTH;

    logic [bmf_pkg::BOUND_W-1:0] r_bound;
    bmf_pkg::t_ctrl_cmd          cmd;
    bmf_pkg::t_dp_stat           stat;
    logic [2:0]                  res_status;
    logic [T-1:0]                res_thr;
    logic [D-1:0]                res_data;
    logic                        res_dv;
    logic                        cfg_wr;
    logic                        req_xfer;

    // APB register file: only the bound register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= '0;
        end else if (cfg_wr && paddr[2] == bmf_pkg::CFG_IDX_BOUND) begin
            r_bound <= pwdata[bmf_pkg::BOUND_W-1:0];
        end
    end

    assign prdata = (paddr[2] == bmf_pkg::CFG_IDX_BOUND)
                  ? bmf_pkg::APB_DW'(r_bound) : '0;

    bmf_ctrl #(.WAITER_DEPTH(WAITER_DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bmf_dp #(
        .ITEM_DEPTH      (ITEM_DEPTH),
        .WAITER_DEPTH    (WAITER_DEPTH),
        .DATA_WIDTH      (DATA_WIDTH),
        .THREAD_ID_WIDTH (THREAD_ID_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_bound         (r_bound),
        .i_req_type      (i_s_axis_tuser),
        .i_thread_id     (i_s_axis_tdata[T-1:0]),
        .i_item_data     (i_s_axis_tdata[T+:D]),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_status        (res_status),
        .o_target_thread (res_thr),
        .o_out_data      (res_data),
        .o_data_valid    (res_dv),
        .o_last          (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = TD_W'({res_data, res_thr});
    assign o_m_axis_tuser = {res_dv, res_status};

    assign req_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // a transfer in always makes the sequencer busy on the next cycle
    `BMF_ASSERT(a_busy_after_req, req_xfer |=> !o_s_axis_tready, "ready after request transfer")
    // at most one result loaded per cycle
    `BMF_ASSERT(a_one_emit, ($onehot0({cmd.cas_get, cmd.cas_put, cmd.emit_final})), "two results in one cycle")
    // a result is only loaded into a free output register
    `BMF_ASSERT_IMP(a_emit_free, (cmd.cas_get || cmd.cas_put || cmd.emit_final), stat.out_free, "result overwritten")

endmodule

`default_nettype wire
